@@ design/sdrn_pkg.sv @@
// Shared constants, codes and command/status types of the divergence RMS block.
`default_nettype none
package sdrn_pkg;

	localparam int FRAC_BITS = 16;

	localparam int VEL_W   = 32;
	localparam int INV_W   = 32;
	localparam int CNT_W   = 25;
	localparam int PROD_W  = 64;
	localparam int TERM_W  = PROD_W - FRAC_BITS + 1;
	localparam int SUM_W   = TERM_W + 1;
	localparam int REM_S_W = 34;

	localparam int DIV_STEPS  = 64;
	localparam int SQRT_STEPS = 32;
	localparam int STEP_W     = $clog2(DIV_STEPS);

	typedef logic [1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_INV_DX     = 2'd0;
	localparam cfg_idx_t CFG_INV_DY     = 2'd1;
	localparam cfg_idx_t CFG_CELL_COUNT = 2'd2;

	localparam logic [INV_W-1:0] INV_RESET   = 32'd65536;
	localparam logic [CNT_W-1:0] COUNT_RESET = 25'd1;

	typedef enum logic [1:0] {
		MUL_X,
		MUL_Y,
		MUL_SQ
	} mul_sel_t;

	typedef struct packed {
		logic     load;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     term_x;
		logic     sum;
		logic     sat;
		logic     acc;
		logic     div_step;
		logic     sqrt_step;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		logic last;
	} status_t;

endpackage
`default_nettype wire

@@ design/sdrn_ctrl.sv @@
// Sequencer: walks one cell through the shared multiplier, divider and root steps.
`default_nettype none
module sdrn_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cell_valid,
	output logic                  cell_stall,
	input  wire logic             result_stall,
	output logic                  result_valid,
	input  wire sdrn_pkg::status_t status,
	output sdrn_pkg::cmd_t        cmd
);
	import sdrn_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MX,
		S_MY,
		S_SUM,
		S_SAT,
		S_SQ,
		S_ACC,
		S_DIV,
		S_SQRT,
		S_OUT
	} state_t;

	state_t            state_q;
	logic [STEP_W-1:0] step_q;
	logic              result_valid_q;

	assign cell_stall   = (state_q != S_IDLE);
	assign result_valid = result_valid_q;

	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE: cmd.load = cell_valid;
			S_MX: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_X;
			end
			S_MY: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_Y;
				cmd.term_x  = 1'b1;
			end
			S_SUM: cmd.sum = 1'b1;
			S_SAT: cmd.sat = 1'b1;
			S_SQ: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_SQ;
			end
			S_ACC:  cmd.acc = 1'b1;
			S_DIV:  cmd.div_step = 1'b1;
			S_SQRT: cmd.sqrt_step = 1'b1;
			S_OUT:  cmd.out_load = !(result_valid_q && result_stall);
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			step_q         <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load)
				result_valid_q <= 1'b1;
			else if (!result_stall)
				result_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: if (cell_valid) state_q <= S_MX;
				S_MX:   state_q <= S_MY;
				S_MY:   state_q <= S_SUM;
				S_SUM:  state_q <= S_SAT;
				S_SAT:  state_q <= S_SQ;
				S_SQ:   state_q <= S_ACC;
				S_ACC: begin
					step_q  <= '0;
					state_q <= status.last ? S_DIV : S_OUT;
				end
				S_DIV: begin
					if (step_q == STEP_W'(DIV_STEPS - 1)) begin
						step_q  <= '0;
						state_q <= S_SQRT;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				S_SQRT: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(SQRT_STEPS - 1))
						state_q <= S_OUT;
				end
				S_OUT: if (cmd.out_load) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		cell_valid && !cell_stall |=> state_q == S_MX)
		else $error("accepted request did not start the multiply sequence");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(result_valid_q && result_stall))
		else $error("result register loaded while a stalled result waits");

	a_div_to_sqrt: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV && step_q == STEP_W'(DIV_STEPS - 1) |=>
			state_q == S_SQRT && step_q == '0)
		else $error("divider did not hand over to the root after its last step");

endmodule
`default_nettype wire

@@ design/sdrn_dpath.sv @@
// Datapath: config registers, shared multiplier, accumulator, divider and root.
`default_nettype none
module sdrn_dpath (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_valid,
	input  wire sdrn_pkg::cfg_idx_t         cfg_index,
	input  wire logic [31:0]                cfg_data,
	input  wire logic signed [31:0]         u_east,
	input  wire logic signed [31:0]         u_west,
	input  wire logic signed [31:0]         v_north,
	input  wire logic signed [31:0]         v_south,
	input  wire logic                       last_cell,
	input  wire sdrn_pkg::cmd_t             cmd,
	output sdrn_pkg::status_t               status,
	output logic signed [31:0]              divergence,
	output logic [31:0]                     rms_norm,
	output logic                            sweep_done,
	output logic                            saturated
);
	import sdrn_pkg::*;

	logic [INV_W-1:0] inv_dx_q, inv_dy_q;
	logic [CNT_W-1:0] cell_count_q;

	logic [VEL_W-1:0]   dx_mag_q, dy_mag_q;
	logic               dx_neg_q, dy_neg_q, last_q;
	logic [PROD_W-1:0]  prod_q;
	logic signed [TERM_W-1:0] term_x_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic signed [31:0] div_q;
	logic [31:0]        div_mag_q;
	logic [PROD_W-1:0]  ss_q;
	logic               ovf_q;
	logic [PROD_W-1:0]  dq_q;
	logic [CNT_W-1:0]   rem_q;
	logic [REM_S_W-1:0] srem_q;
	logic [31:0]        root_q;

	// face differences, magnitude and sign
	logic signed [VEL_W:0] dx, dy;
	logic [VEL_W:0]        dx_abs, dy_abs;
	always_comb begin
		dx     = {u_east[31], u_east} - {u_west[31], u_west};
		dy     = {v_north[31], v_north} - {v_south[31], v_south};
		dx_abs = dx[VEL_W] ? (VEL_W+1)'(-dx) : dx;
		dy_abs = dy[VEL_W] ? (VEL_W+1)'(-dy) : dy;
	end

	// shared 32x32 multiplier
	logic [31:0] mul_a, mul_b;
	always_comb begin
		case (cmd.mul_sel)
			MUL_X: begin
				mul_a = dx_mag_q;
				mul_b = inv_dx_q;
			end
			MUL_Y: begin
				mul_a = dy_mag_q;
				mul_b = inv_dy_q;
			end
			MUL_SQ: begin
				mul_a = div_mag_q;
				mul_b = div_mag_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// truncate magnitude, then apply sign
	function automatic logic signed [TERM_W-1:0] signed_term(input logic [PROD_W-1:0] p,
		input logic neg);
		logic signed [TERM_W-1:0] t;
		t = $signed({1'b0, p[PROD_W-1:FRAC_BITS]});
		return neg ? -t : t;
	endfunction

	logic signed [TERM_W-1:0] term_y;
	logic [SUM_W-32:0]        sum_hi;
	logic                     in_range;
	logic [31:0]              sum_abs;
	always_comb begin
		term_y   = signed_term(prod_q, dy_neg_q);
		sum_hi   = sum_q[SUM_W-1:31];
		in_range = (&sum_hi) || !(|sum_hi);
		sum_abs  = sum_q[31] ? (~sum_q[31:0] + 32'd1) : sum_q[31:0];
	end

	logic [PROD_W:0] ss_add;
	assign ss_add = {1'b0, ss_q} + {1'b0, prod_q};

	// restoring divide step
	logic [CNT_W-1:0] n_eff;
	logic [CNT_W:0]   d_trial, d_diff;
	logic             d_ge;
	always_comb begin
		n_eff   = (cell_count_q == '0) ? CNT_W'(1) : cell_count_q;
		d_trial = {rem_q, dq_q[PROD_W-1]};
		d_diff  = d_trial - {1'b0, n_eff};
		d_ge    = d_trial >= {1'b0, n_eff};
	end

	// digit-by-digit root step, two radicand bits a step
	logic [REM_S_W+1:0] s_r, s_trial, s_diff;
	logic               s_ge;
	always_comb begin
		s_r     = {srem_q, dq_q[PROD_W-1:PROD_W-2]};
		s_trial = {2'b00, root_q, 2'b01};
		s_diff  = s_r - s_trial;
		s_ge    = s_r >= s_trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_dx_q     <= INV_RESET;
			inv_dy_q     <= INV_RESET;
			cell_count_q <= COUNT_RESET;
			ss_q         <= '0;
			ovf_q        <= 1'b0;
			last_q       <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					CFG_INV_DX:     inv_dx_q     <= cfg_data;
					CFG_INV_DY:     inv_dy_q     <= cfg_data;
					CFG_CELL_COUNT: cell_count_q <= cfg_data[CNT_W-1:0];
					default: ;
				endcase
			end
			if (cmd.load)
				last_q <= last_cell;
			if (cmd.sat && !in_range)
				ovf_q <= 1'b1;
			if (cmd.acc)
				ss_q <= ss_add[PROD_W] ? '1 : ss_add[PROD_W-1:0];
			if (cmd.acc && ss_add[PROD_W])
				ovf_q <= 1'b1;
			// sweep ends: clear after the flag has gone out with the result
			if (cmd.out_load && last_q) begin
				ss_q  <= '0;
				ovf_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dx_mag_q <= dx_abs[VEL_W-1:0];
			dy_mag_q <= dy_abs[VEL_W-1:0];
			dx_neg_q <= dx[VEL_W];
			dy_neg_q <= dy[VEL_W];
		end
		if (cmd.mul_en)
			prod_q <= mul_a * mul_b;
		if (cmd.term_x)
			term_x_q <= signed_term(prod_q, dx_neg_q);
		if (cmd.sum)
			sum_q <= SUM_W'(term_x_q) + SUM_W'(term_y);
		if (cmd.sat) begin
			if (in_range) begin
				div_q     <= sum_q[31:0];
				div_mag_q <= sum_abs;
			end else if (sum_q[SUM_W-1]) begin
				div_q     <= 32'sh8000_0000;
				div_mag_q <= 32'h8000_0000;
			end else begin
				div_q     <= 32'sh7fff_ffff;
				div_mag_q <= 32'h7fff_ffff;
			end
		end
		if (cmd.acc) begin
			dq_q   <= ss_add[PROD_W] ? '1 : ss_add[PROD_W-1:0];
			rem_q  <= '0;
			srem_q <= '0;
			root_q <= '0;
		end
		if (cmd.div_step) begin
			dq_q  <= {dq_q[PROD_W-2:0], d_ge};
			rem_q <= d_ge ? d_diff[CNT_W-1:0] : d_trial[CNT_W-1:0];
		end
		if (cmd.sqrt_step) begin
			dq_q   <= {dq_q[PROD_W-3:0], 2'b00};
			srem_q <= s_ge ? s_diff[REM_S_W-1:0] : s_r[REM_S_W-1:0];
			root_q <= {root_q[30:0], s_ge};
		end
		if (cmd.out_load) begin
			divergence <= div_q;
			rms_norm   <= last_q ? root_q : 32'd0;
			sweep_done <= last_q;
			saturated  <= ovf_q;
		end
	end

	assign status.last = last_q;

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> rem_q < n_eff)
		else $error("divider remainder reached the divisor");

	a_root_rem: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sqrt_step |-> srem_q <= {1'b0, root_q, 1'b0})
		else $error("root remainder exceeds twice the partial root");

endmodule
`default_nettype wire

@@ design/staggered_divergence_rms_norm.sv @@
// Top level: staggered-grid cell divergence with a running RMS norm per sweep.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-------------------------------------------
//  cfg      | cfg_valid / cfg_ready     | cfg_index, cfg_data
//  cell     | cell_valid / cell_stall   | u_east, u_west, v_north, v_south, last_cell
//  result   | result_valid / result_stall | divergence, rms_norm, sweep_done, saturated
//
// A new cell is accepted only in idle, once the previous result has been registered.
// The cell steps through MX, MY, SUM, SAT, SQ and ACC, since the two products and the
// square share one 32x32 multiplier; its result is registered in OUT. The last cell of
// a sweep adds a 64-step restoring divide by cell_count, then a 32-step root.
// arst_n resets spacing to 1.0, cell_count to 1 and clears the sum and flag.
// A result held by result_stall stalls the sequencer only at its final step;
// cfg_ready is always high.
`default_nettype none
module staggered_divergence_rms_norm (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_valid,
	output logic                         cfg_ready,
	input  wire sdrn_pkg::cfg_idx_t      cfg_index,
	input  wire logic [31:0]             cfg_data,
	input  wire logic                    cell_valid,
	output logic                         cell_stall,
	input  wire logic signed [31:0]      u_east,
	input  wire logic signed [31:0]      u_west,
	input  wire logic signed [31:0]      v_north,
	input  wire logic signed [31:0]      v_south,
	input  wire logic                    last_cell,
	output logic                         result_valid,
	input  wire logic                    result_stall,
	output logic signed [31:0]           divergence,
	output logic [31:0]                  rms_norm,
	output logic                         sweep_done,
	output logic                         saturated
);
	import sdrn_pkg::*;

	cmd_t    cmd;
	status_t status;

	assign cfg_ready = 1'b1;

	sdrn_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cell_valid   (cell_valid),
		.cell_stall   (cell_stall),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.status       (status),
		.cmd          (cmd)
	);

	sdrn_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid && cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.u_east     (u_east),
		.u_west     (u_west),
		.v_north    (v_north),
		.v_south    (v_south),
		.last_cell  (last_cell),
		.cmd        (cmd),
		.status     (status),
		.divergence (divergence),
		.rms_norm   (rms_norm),
		.sweep_done (sweep_done),
		.saturated  (saturated)
	);

endmodule
`default_nettype wire

@@ tb/sv/tb.sv @@
// Self-checking testbench for the staggered-grid divergence / RMS norm block.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sdrn_pkg::*;

	localparam int          CYCLE_LIMIT = 1_000_000;
	localparam int          PHASE_CELLS = 130;
	localparam logic [31:0] V_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] V_MIN = 32'h8000_0000;
	localparam logic [31:0] ONE   = 32'h0001_0000;
	localparam logic [31:0] ZERO  = 32'd0;
	localparam longint      DIV_HI = 64'sd2147483647;
	localparam longint      DIV_LO = -64'sd2147483648;
	// index 3 addresses no register; writes to it must be ignored
	localparam cfg_idx_t    CFG_SPARE = 2'd3;

	typedef struct packed {
		logic signed [31:0] ue;
		logic signed [31:0] uw;
		logic signed [31:0] vn;
		logic signed [31:0] vs;
		logic               last;
	} cell_req_t;

	typedef struct packed {
		logic signed [31:0] div;
		logic [31:0]        rms;
		logic               done;
		logic               sat;
	} cell_result_t;

	typedef struct packed {
		cell_req_t    req;
		logic         typed;
		cell_result_t want;
	} directed_row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	cfg_idx_t           cfg_index = CFG_INV_DX;
	logic [31:0]        cfg_data = '0;
	logic               cell_valid = 1'b0;
	logic               cell_stall;
	logic signed [31:0] u_east = '0;
	logic signed [31:0] u_west = '0;
	logic signed [31:0] v_north = '0;
	logic signed [31:0] v_south = '0;
	logic               last_cell = 1'b0;
	logic               result_valid;
	logic               result_stall = 1'b0;
	logic signed [31:0] divergence;
	logic [31:0]        rms_norm;
	logic               sweep_done;
	logic               saturated;

	// predictor copy of the block's registers and sweep state
	logic [31:0] spacing_x = INV_RESET;
	logic [31:0] spacing_y = INV_RESET;
	logic [24:0] cells_total = COUNT_RESET;
	logic [63:0] square_total = '0;
	logic        overflow_flag = 1'b0;

	cell_result_t  expected_results[$];
	directed_row_t directed_rows[0:14];
	int            mismatches = 0;
	int            results_seen = 0;
	int            cycles = 0;
	int            send_gap_pct = 0;
	int            stall_pct = 0;

	staggered_divergence_rms_norm dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cell_valid(cell_valid),
		.cell_stall(cell_stall),
		.u_east(u_east),
		.u_west(u_west),
		.v_north(v_north),
		.v_south(v_south),
		.last_cell(last_cell),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.divergence(divergence),
		.rms_norm(rms_norm),
		.sweep_done(sweep_done),
		.saturated(saturated)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		result_stall <= ($urandom_range(99) < stall_pct);
	end

	task automatic note_mismatch(input string field, input logic [31:0] got,
			input logic [31:0] want);
		mismatches++;
		$display("ERROR result %0d %s: got %h, expected %h", results_seen, field, got, want);
	endtask

	// |diff| * inv, truncated toward zero after the fraction shift, sign restored
	function automatic longint scaled_term(input longint diff, input logic [31:0] inv);
		logic [63:0] mag;
		logic [63:0] t;
		mag = (diff < 0) ? 64'(-diff) : 64'(diff);
		t = (mag * {32'd0, inv}) >> FRAC_BITS;
		return (diff < 0) ? -longint'(t) : longint'(t);
	endfunction

	function automatic logic [31:0] int_sqrt(input logic [63:0] x);
		logic [31:0] root;
		logic [31:0] cand;
		root = '0;
		for (int b = 31; b >= 0; b--) begin
			cand = root | (32'd1 << b);
			if ({32'd0, cand} * {32'd0, cand} <= x)
				root = cand;
		end
		return root;
	endfunction

	function automatic cell_result_t predict_cell(input cell_req_t c);
		longint       d;
		logic [63:0]  m;
		logic [63:0]  sq;
		logic [64:0]  acc;
		logic [24:0]  n;
		cell_result_t r;
		d = scaled_term(longint'($signed(c.ue)) - longint'($signed(c.uw)), spacing_x)
			+ scaled_term(longint'($signed(c.vn)) - longint'($signed(c.vs)), spacing_y);
		if (d > DIV_HI) begin
			d = DIV_HI;
			overflow_flag = 1'b1;
		end else if (d < DIV_LO) begin
			d = DIV_LO;
			overflow_flag = 1'b1;
		end
		m = (d < 0) ? 64'(-d) : 64'(d);
		sq = m * m;
		acc = {1'b0, square_total} + {1'b0, sq};
		if (acc[64]) begin
			square_total = '1;
			overflow_flag = 1'b1;
		end else begin
			square_total = acc[63:0];
		end
		r.div = d[31:0];
		r.rms = '0;
		r.done = c.last;
		r.sat = overflow_flag;
		if (c.last) begin
			n = (cells_total == 0) ? 25'd1 : cells_total;
			r.rms = int_sqrt(square_total / {39'd0, n});
			square_total = '0;
			overflow_flag = 1'b0;
		end
		return r;
	endfunction

	always @(posedge clk) begin
		cell_result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_results.size() == 0) begin
				note_mismatch("unexpected, divergence", divergence, ZERO);
			end else begin
				want = expected_results.pop_front();
				if (divergence !== want.div)
					note_mismatch("divergence", divergence, want.div);
				if (rms_norm !== want.rms)
					note_mismatch("rms_norm", rms_norm, want.rms);
				if (sweep_done !== want.done)
					note_mismatch("sweep_done", {31'd0, sweep_done}, {31'd0, want.done});
				if (saturated !== want.sat)
					note_mismatch("saturated", {31'd0, saturated}, {31'd0, want.sat});
			end
			results_seen++;
		end
	end

	task automatic write_reg(input cfg_idx_t idx, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_INV_DX:     spacing_x = data;
			CFG_INV_DY:     spacing_y = data;
			CFG_CELL_COUNT: cells_total = data[24:0];
			default: ;
		endcase
	endtask

	task automatic configure(input logic [31:0] dx, input logic [31:0] dy,
			input logic [31:0] cnt, input bit with_spare);
		if (with_spare)
			write_reg(CFG_SPARE, $urandom);
		write_reg(CFG_INV_DX, dx);
		write_reg(CFG_INV_DY, dy);
		write_reg(CFG_CELL_COUNT, cnt);
		cfg_valid <= 1'b0;
	endtask

	// drop the cell request and hold off until every result is back
	task automatic wait_drained();
		cell_valid <= 1'b0;
		do @(posedge clk); while (expected_results.size() != 0);
	endtask

	task automatic push_cell(input cell_req_t c, input logic typed, input cell_result_t want);
		cell_result_t pred;
		while ($urandom_range(99) < send_gap_pct) begin
			cell_valid <= 1'b0;
			@(posedge clk);
		end
		cell_valid <= 1'b1;
		u_east <= c.ue;
		u_west <= c.uw;
		v_north <= c.vn;
		v_south <= c.vs;
		last_cell <= c.last;
		do @(posedge clk); while (cell_stall);
		// predictor runs even on typed rows so the sweep state stays in step
		pred = predict_cell(c);
		expected_results.push_back(typed ? want : pred);
	endtask

	function automatic logic [31:0] pick_velocity();
		int unsigned sel;
		sel = $urandom_range(9);
		case (sel)
			0, 1, 2, 3: return $urandom_range(32'h0008_0000) - 32'h0004_0000;
			4, 5:       return $urandom;
			6: begin
				case ($urandom_range(4))
					0: return V_MAX;
					1: return V_MIN;
					2: return 32'hFFFF_FFFF;
					3: return 32'd1;
					default: return ZERO;
				endcase
			end
			default:    return $urandom_range(32'h0200_0000) - 32'h0100_0000;
		endcase
	endfunction

	initial begin
		cell_req_t c;
		int        sent;
		int        sweep_len;
		bit        ragged;

		directed_rows = '{
			'{'{ZERO, ZERO, ZERO, ZERO, 1'b1}, 1'b1, '{ZERO, ZERO, 1'b1, 1'b0}},
			'{'{V_MAX, V_MIN, ZERO, ZERO, 1'b0}, 1'b1, '{V_MAX, ZERO, 1'b0, 1'b1}},
			'{'{V_MIN, V_MAX, ZERO, ZERO, 1'b1}, 1'b0, '0},
			'{'{ZERO, ZERO, V_MAX, V_MIN, 1'b0}, 1'b1, '{V_MAX, ZERO, 1'b0, 1'b1}},
			'{'{ZERO, ZERO, V_MIN, V_MAX, 1'b1}, 1'b0, '0},
			// both terms out of range but they cancel exactly
			'{'{V_MAX, V_MIN, V_MIN, V_MAX, 1'b0}, 1'b1, '{ZERO, ZERO, 1'b0, 1'b0}},
			'{'{V_MIN, V_MIN, V_MAX, V_MAX, 1'b1}, 1'b1, '{ZERO, ZERO, 1'b1, 1'b0}},
			// four squares of 2^62 push the sum past its top
			'{'{V_MIN, ZERO, ZERO, ZERO, 1'b0}, 1'b1, '{V_MIN, ZERO, 1'b0, 1'b0}},
			'{'{V_MIN, ZERO, ZERO, ZERO, 1'b0}, 1'b1, '{V_MIN, ZERO, 1'b0, 1'b0}},
			'{'{V_MIN, ZERO, ZERO, ZERO, 1'b0}, 1'b1, '{V_MIN, ZERO, 1'b0, 1'b0}},
			'{'{V_MIN, ZERO, ZERO, ZERO, 1'b1}, 1'b1, '{V_MIN, 32'hFFFF_FFFF, 1'b1, 1'b1}},
			'{'{32'h0001_8000, 32'h0000_8000, ONE, 32'hFFFF_0000, 1'b0}, 1'b1,
				'{32'h0003_0000, ZERO, 1'b0, 1'b0}},
			'{'{ZERO, ONE, ZERO, ZERO, 1'b1}, 1'b0, '0},
			'{'{V_MAX, ZERO, ZERO, ZERO, 1'b0}, 1'b1, '{V_MAX, ZERO, 1'b0, 1'b0}},
			'{'{32'hFFFF_FFFF, ZERO, ZERO, 32'd1, 1'b1}, 1'b0, '0}
		};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			push_cell(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);

		for (int ph = 0; ph < 8; ph++) begin
			wait_drained();
			case (ph)
				0: configure(ONE, ONE, 32'd25, 1'b0);
				1: configure(ZERO, 32'hFFFF_FFFF, ZERO, 1'b0);
				2: configure(32'hFFFF_FFFF, ZERO, 32'h0100_0000, 1'b0);
				3: configure($urandom, $urandom, $urandom_range(1, 400), 1'b0);
				4: configure(32'h0000_8000, 32'h0004_0000, 32'hFE00_0064, 1'b1);
				5: configure(32'h0010_0000, 32'h0000_1000, 32'h01FF_FFFF, 1'b0);
				6: configure($urandom, $urandom, $urandom, 1'b0);
				default: configure(32'd1, 32'd1, 32'd3, 1'b0);
			endcase
			case (ph % 4)
				0: begin send_gap_pct = 0;  stall_pct = 0;  end
				1: begin send_gap_pct = 66; stall_pct = 0;  end
				2: begin send_gap_pct = 0;  stall_pct = 66; end
				default: begin send_gap_pct = 35; stall_pct = 35; end
			endcase
			sent = 0;
			while (sent < PHASE_CELLS) begin
				sweep_len = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 40);
				// now and then a sweep with stray end marks
				ragged = ($urandom_range(11) == 0);
				for (int k = 0; k < sweep_len && sent < PHASE_CELLS; k++) begin
					if ($urandom_range(59) == 0)
						wait_drained();
					c.ue = pick_velocity();
					c.uw = pick_velocity();
					c.vn = pick_velocity();
					c.vs = pick_velocity();
					c.last = ragged ? ($urandom_range(3) == 0) : (k == sweep_len - 1);
					push_cell(c, 1'b0, '0);
					sent++;
				end
			end
		end

		wait_drained();
		repeat (150) @(posedge clk);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

@@ sim.f @@
design/sdrn_pkg.sv
design/sdrn_ctrl.sv
design/sdrn_dpath.sv
design/staggered_divergence_rms_norm.sv
tb/sv/tb.sv
